@@ rtl/kjvr_pkg.sv @@
`default_nettype none

package kjvr_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS  = 16;
  localparam int VEL_W      = 20;
  localparam int LIM_W      = 19;
  localparam int POS_W      = 19;
  localparam int AGE_W      = 11;
  localparam int STEP_W     = 16;
  localparam int HOLD_W     = 10;
  localparam int JOINT_W    = 3;
  localparam int NUM_CMD    = 6;
  localparam int JOINTS_DEF = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int KEY_W      = 8;
  localparam int KIND_W     = 2;

  // Stream layout.
  localparam int S_TDATA_W  = 128;
  localparam int M_TDATA_W  = 144;
  localparam int POS_VALID_BIT = KEY_W;
  localparam int POS_LSB    = KEY_W + 1;

  // Item kinds carried in tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_KEY  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_STEP  = 3'd0,
    CFG_DECEL_STEP  = 3'd1,
    CFG_HOLD_TICKS  = 3'd2,
    CFG_LIMIT_STEP  = 3'd3,
    CFG_LIMIT_RESET = 3'd4,
    CFG_LIMIT_CEIL  = 3'd5,
    CFG_LIMIT_FLOOR = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_e;

  // Key codes (ASCII).
  localparam logic [KEY_W-1:0] KEY_J0_POS = 8'h31;
  localparam logic [KEY_W-1:0] KEY_J0_NEG = 8'h32;
  localparam logic [KEY_W-1:0] KEY_J1_POS = 8'h33;
  localparam logic [KEY_W-1:0] KEY_J1_NEG = 8'h34;
  localparam logic [KEY_W-1:0] KEY_J2_POS = 8'h35;
  localparam logic [KEY_W-1:0] KEY_J2_NEG = 8'h36;
  localparam logic [KEY_W-1:0] KEY_J3_POS = 8'h37;
  localparam logic [KEY_W-1:0] KEY_J3_NEG = 8'h38;
  localparam logic [KEY_W-1:0] KEY_J4_POS = 8'h39;
  localparam logic [KEY_W-1:0] KEY_J4_NEG = 8'h30;
  localparam logic [KEY_W-1:0] KEY_J5_POS = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_J5_NEG = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_LIM_DN  = 8'h61;
  localparam logic [KEY_W-1:0] KEY_LIM_RST = 8'h73;
  localparam logic [KEY_W-1:0] KEY_LIM_UP  = 8'h64;

  // Configuration reset values.
  localparam logic [STEP_W-1:0] ACCEL_RST      = 16'd412;
  localparam logic [STEP_W-1:0] DECEL_RST      = 16'd206;
  localparam logic [HOLD_W-1:0] HOLD_RST       = 10'd100;
  localparam logic [STEP_W-1:0] LIM_STEP_RST   = 16'd6554;
  localparam logic [LIM_W-1:0]  LIM_RESET_RST  = 19'd205887;
  localparam logic [LIM_W-1:0]  LIM_CEIL_RST   = 19'd411775;
  localparam logic [LIM_W-1:0]  LIM_FLOOR_RST  = 19'd6554;
  localparam logic [LIM_W-1:0]  LIM_MAX        = '1;

  // Converts a Q16 constant to the working fraction width, rounding to nearest.
  function automatic int rescale(input int q16);
    int mag;
    mag = (q16 < 0) ? -q16 : q16;
    if (FRAC_BITS >= 16) begin
      mag = mag * (1 << (FRAC_BITS - 16));
    end else begin
      mag = (mag + (1 << (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
    end
    return (q16 < 0) ? -mag : mag;
  endfunction

  localparam int VEL_LIMIT_RST_I = rescale(51472);
  localparam logic [LIM_W-1:0] VEL_LIMIT_RST = VEL_LIMIT_RST_I[LIM_W-1:0];

  // Joint position window, radians.
  localparam int JOINT_LO [NUM_CMD] = '{
    rescale(-205888), rescale(-194452), rescale(-5719),
    rescale(-197309), rescale(-115527), rescale(-197309)
  };
  localparam int JOINT_HI [NUM_CMD] = '{
    rescale(137259), rescale(11438), rescale(205888),
    rescale(197309), rescale(115527), rescale(197309)
  };

  // Direction key decode result.
  typedef struct packed {
    logic               hit;
    logic [JOINT_W-1:0] joint;
    logic               neg;
  } dir_key_t;

  // Control broadcast to every lane.
  typedef struct packed {
    logic               tick;
    logic               key_hit;
    logic [JOINT_W-1:0] key_joint;
    logic               key_neg;
  } lane_ctrl_t;

  // Ramp settings shared by the lanes.
  typedef struct packed {
    logic [STEP_W-1:0] accel;
    logic [STEP_W-1:0] decel;
    logic [HOLD_W-1:0] hold;
    logic [LIM_W-1:0]  limit;
  } ramp_cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [LIM_W-1:0]                limit;
    logic [NUM_CMD-1:0][VEL_W-1:0]   cmd;
  } result_t;

  function automatic dir_key_t dir_key_decode(input logic [KEY_W-1:0] code);
    dir_key_t r;
    r = '0;
    r.hit = 1'b1;
    case (code)
      KEY_J0_POS: begin r.joint = 3'd0; r.neg = 1'b0; end
      KEY_J0_NEG: begin r.joint = 3'd0; r.neg = 1'b1; end
      KEY_J1_POS: begin r.joint = 3'd1; r.neg = 1'b0; end
      KEY_J1_NEG: begin r.joint = 3'd1; r.neg = 1'b1; end
      KEY_J2_POS: begin r.joint = 3'd2; r.neg = 1'b0; end
      KEY_J2_NEG: begin r.joint = 3'd2; r.neg = 1'b1; end
      KEY_J3_POS: begin r.joint = 3'd3; r.neg = 1'b0; end
      KEY_J3_NEG: begin r.joint = 3'd3; r.neg = 1'b1; end
      KEY_J4_POS: begin r.joint = 3'd4; r.neg = 1'b0; end
      KEY_J4_NEG: begin r.joint = 3'd4; r.neg = 1'b1; end
      KEY_J5_POS: begin r.joint = 3'd5; r.neg = 1'b0; end
      KEY_J5_NEG: begin r.joint = 3'd5; r.neg = 1'b1; end
      default:    r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/kjvr_lane.sv @@
`default_nettype none

module kjvr_lane #(
  parameter int LANE = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kjvr_pkg::lane_ctrl_t          ctrl_i,
  input  wire kjvr_pkg::ramp_cfg_t           cfg_i,
  output logic signed [kjvr_pkg::VEL_W-1:0]  vel_o
);

  localparam int VW = kjvr_pkg::VEL_W;

  logic [kjvr_pkg::AGE_W-1:0] age_q, age_d, age_inc;
  logic                       pos_q, pos_d, neg_q, neg_d;
  logic signed [VW-1:0]       vel_q, vel_d;
  logic                       drop, lat_pos, lat_neg, key_mine;
  logic signed [VW:0]         v, lim, acc, dec, vnext;

  // Aging, latch drop and the ramp step for one tick.
  always_comb begin
    age_inc = (age_q == '1) ? age_q : age_q + 1'b1;
    drop    = age_inc > {1'b0, cfg_i.hold};
    lat_pos = pos_q & ~drop;
    lat_neg = neg_q & ~drop;

    v   = {vel_q[VW-1], vel_q};
    lim = {2'b00, cfg_i.limit};
    acc = {5'b00000, cfg_i.accel};
    dec = {5'b00000, cfg_i.decel};

    if (lat_pos) begin
      vnext = (v < lim - acc) ? v + acc : lim;
    end else if (lat_neg) begin
      vnext = (v > acc - lim) ? v - acc : -lim;
    end else if (v > dec) begin
      vnext = v - dec;
    end else if (v < -dec) begin
      vnext = v + dec;
    end else begin
      vnext = '0;
    end
  end

  assign key_mine = ctrl_i.key_hit && (ctrl_i.key_joint == kjvr_pkg::JOINT_W'(LANE));

  // Next-state selection for tick and key transactions.
  always_comb begin
    age_d = age_q;
    pos_d = pos_q;
    neg_d = neg_q;
    vel_d = vel_q;
    if (ctrl_i.tick) begin
      age_d = age_inc;
      pos_d = lat_pos;
      neg_d = lat_neg;
      vel_d = vnext[VW-1:0];
    end else if (key_mine) begin
      age_d = '0;
      if (ctrl_i.key_neg) begin
        neg_d = 1'b1;
      end else begin
        pos_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
      pos_q <= 1'b0;
      neg_q <= 1'b0;
      vel_q <= '0;
    end else begin
      age_q <= age_d;
      pos_q <= pos_d;
      neg_q <= neg_d;
      vel_q <= vel_d;
    end
  end

  assign vel_o = vel_q;

endmodule

`default_nettype wire

@@ rtl/kjvr_out.sv @@
`default_nettype none

module kjvr_out (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic                                             push_i,
  input  wire logic                                             pos_valid_i,
  input  wire logic [kjvr_pkg::NUM_CMD-1:0][kjvr_pkg::POS_W-1:0] pos_i,
  input  wire logic [kjvr_pkg::NUM_CMD-1:0][kjvr_pkg::VEL_W-1:0] vel_i,
  input  wire logic [kjvr_pkg::LIM_W-1:0]                        limit_i,
  output logic                                                  in_ready_o,
  output logic                                                  out_valid_o,
  input  wire logic                                             out_ready_i,
  output kjvr_pkg::result_t                                     out_data_o
);

  localparam int VW = kjvr_pkg::VEL_W;

  kjvr_pkg::result_t res;
  kjvr_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_vq, out_vd, skid_vq, skid_vd;
  logic              pop;

  // Merge the lanes: halve the wrist joints, then zero motion past the window.
  always_comb begin
    logic signed [VW-1:0]               c;
    logic signed [kjvr_pkg::POS_W-1:0]  p;
    res.limit = limit_i;
    for (int i = 0; i < kjvr_pkg::NUM_CMD; i++) begin
      c = $signed(vel_i[i]);
      p = $signed(pos_i[i]);
      if (i >= 3) begin
        c = c >>> 1;
      end
      if (pos_valid_i) begin
        if ((p < kjvr_pkg::JOINT_LO[i]) && (c < 0)) begin
          c = '0;
        end
        if ((p > kjvr_pkg::JOINT_HI[i]) && (c > 0)) begin
          c = '0;
        end
      end
      res.cmd[i] = c;
    end
  end

  // Output register with a skid stage behind it.
  assign pop = out_vq && out_ready_i;

  always_comb begin
    out_d   = out_q;
    out_vd  = out_vq;
    skid_d  = skid_q;
    skid_vd = skid_vq;
    if (skid_vq) begin
      if (pop) begin
        out_d   = skid_q;
        out_vd  = 1'b1;
        skid_vd = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vq || pop) begin
        out_d  = res;
        out_vd = 1'b1;
      end else begin
        skid_d  = res;
        skid_vd = 1'b1;
      end
    end else if (pop) begin
      out_vd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      out_vq  <= out_vd;
      skid_vq <= skid_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = ~skid_vq;
  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/keyboard_jog_velocity_ramp_unit.sv @@
`default_nettype none

// Jog velocity generator for up to six joints with slew-rate limiting.
// Input stream: tuser carries the item kind (key press, 1 ms tick, command
// request); tdata carries the key byte, the position-valid flag and six
// measured joint positions. A key press latches a joint direction or moves
// the velocity limit; a tick ages the latches and ramps every joint one step.
// Only a command request produces an output transaction: six velocity
// commands (joints 3 to 5 halved, clipped at the joint window when positions
// are valid) and the present velocity limit.
// Throughput is one input transaction per cycle unless the skid stage is full:
// all joints update in parallel lanes in the cycle the transaction is accepted.
// A command result is registered in the output register or the skid stage.
// When the receiver stalls, one result waits in the output register and a
// second in the skid stage; s_axis_tready_o drops only while the skid stage
// is full. Reset clears velocities, latches and hold ages, loads the default
// limit and step settings, and empties the output; no clearing pass is needed.
// The configuration port writes one register per cycle and may be used only
// while no transaction is in flight.
module keyboard_jog_velocity_ramp_unit #(
  parameter int JOINTS = kjvr_pkg::JOINTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input stream.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata from bit 0: key_code[7:0], pos_valid, pos_0 .. pos_5 (19 each), zero pad
  input  wire logic [kjvr_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: kind[1:0]
  input  wire logic [kjvr_pkg::KIND_W-1:0]        s_axis_tuser_i,
  // Output stream.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata from bit 0: cmd_0 .. cmd_5 (20 each), current_limit (19), zero pad
  output logic [kjvr_pkg::M_TDATA_W-1:0]          m_axis_tdata_o,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [kjvr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [kjvr_pkg::LIM_W-1:0]         cfg_wdata_i
);

  localparam int LW = kjvr_pkg::LIM_W;

  logic [kjvr_pkg::STEP_W-1:0] accel_q, decel_q, lim_step_q;
  logic [kjvr_pkg::HOLD_W-1:0] hold_q;
  logic [LW-1:0]               lim_reset_q, lim_ceil_q, lim_floor_q;
  logic [LW-1:0]               limit_q, limit_d;

  logic                  in_fire, in_ready;
  kjvr_pkg::kind_e       kind;
  logic [kjvr_pkg::KEY_W-1:0] key_code;
  kjvr_pkg::dir_key_t    dkey;
  kjvr_pkg::lane_ctrl_t  ctrl;
  kjvr_pkg::ramp_cfg_t   rcfg;
  kjvr_pkg::result_t     res;

  logic signed [JOINTS-1:0][kjvr_pkg::VEL_W-1:0]         lane_vel;
  logic [kjvr_pkg::NUM_CMD-1:0][kjvr_pkg::VEL_W-1:0]     vel;
  logic [kjvr_pkg::NUM_CMD-1:0][kjvr_pkg::POS_W-1:0]     pos;

  assign in_fire  = s_axis_tvalid_i && in_ready;
  assign kind     = kjvr_pkg::kind_e'(s_axis_tuser_i);
  assign key_code = s_axis_tdata_i[kjvr_pkg::KEY_W-1:0];
  assign dkey     = kjvr_pkg::dir_key_decode(key_code);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q     <= kjvr_pkg::ACCEL_RST;
      decel_q     <= kjvr_pkg::DECEL_RST;
      hold_q      <= kjvr_pkg::HOLD_RST;
      lim_step_q  <= kjvr_pkg::LIM_STEP_RST;
      lim_reset_q <= kjvr_pkg::LIM_RESET_RST;
      lim_ceil_q  <= kjvr_pkg::LIM_CEIL_RST;
      lim_floor_q <= kjvr_pkg::LIM_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (kjvr_pkg::cfg_idx_e'(cfg_idx_i))
        kjvr_pkg::CFG_ACCEL_STEP:  accel_q     <= cfg_wdata_i[kjvr_pkg::STEP_W-1:0];
        kjvr_pkg::CFG_DECEL_STEP:  decel_q     <= cfg_wdata_i[kjvr_pkg::STEP_W-1:0];
        kjvr_pkg::CFG_HOLD_TICKS:  hold_q      <= cfg_wdata_i[kjvr_pkg::HOLD_W-1:0];
        kjvr_pkg::CFG_LIMIT_STEP:  lim_step_q  <= cfg_wdata_i[kjvr_pkg::STEP_W-1:0];
        kjvr_pkg::CFG_LIMIT_RESET: lim_reset_q <= cfg_wdata_i;
        kjvr_pkg::CFG_LIMIT_CEIL:  lim_ceil_q  <= cfg_wdata_i;
        kjvr_pkg::CFG_LIMIT_FLOOR: lim_floor_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Velocity limit keys: lower, reload, raise.
  always_comb begin
    logic signed [LW:0]   dn;
    logic signed [LW+1:0] up_bound;
    logic [LW:0]          up;
    dn       = $signed({1'b0, limit_q}) - $signed({4'b0000, lim_step_q});
    up_bound = $signed({2'b00, lim_ceil_q}) - $signed({5'b00000, lim_step_q});
    up       = {1'b0, limit_q} + {4'b0000, lim_step_q};
    limit_d  = limit_q;
    if (in_fire && (kind == kjvr_pkg::KIND_KEY)) begin
      case (key_code)
        kjvr_pkg::KEY_LIM_DN: begin
          if (limit_q > lim_floor_q) begin
            limit_d = (dn < 0) ? '0 : dn[LW-1:0];
          end
        end
        kjvr_pkg::KEY_LIM_RST: limit_d = lim_reset_q;
        kjvr_pkg::KEY_LIM_UP: begin
          if ($signed({2'b00, limit_q}) < up_bound) begin
            limit_d = up[LW] ? kjvr_pkg::LIM_MAX : up[LW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= kjvr_pkg::VEL_LIMIT_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  // Broadcast control and settings to the lanes.
  always_comb begin
    ctrl.tick      = in_fire && (kind == kjvr_pkg::KIND_TICK);
    ctrl.key_hit   = in_fire && (kind == kjvr_pkg::KIND_KEY) && dkey.hit;
    ctrl.key_joint = dkey.joint;
    ctrl.key_neg   = dkey.neg;
    rcfg.accel     = accel_q;
    rcfg.decel     = decel_q;
    rcfg.hold      = hold_q;
    rcfg.limit     = limit_q;
  end

  // One lane per joint.
  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    kjvr_lane #(
      .LANE (j)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .cfg_i  (rcfg),
      .vel_o  (lane_vel[j])
    );
  end

  // Joints without a lane report zero; unpack positions.
  for (genvar k = 0; k < kjvr_pkg::NUM_CMD; k++) begin : g_cmd
    if (k < JOINTS) begin : g_have
      assign vel[k] = lane_vel[k];
    end else begin : g_none
      assign vel[k] = '0;
    end
    assign pos[k] = s_axis_tdata_i[kjvr_pkg::POS_LSB + k*kjvr_pkg::POS_W +: kjvr_pkg::POS_W];
  end

  kjvr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && (kind == kjvr_pkg::KIND_CMD)),
    .pos_valid_i (s_axis_tdata_i[kjvr_pkg::POS_VALID_BIT]),
    .pos_i       (pos),
    .vel_i       (vel),
    .limit_i     (limit_q),
    .in_ready_o  (in_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = {
    (kjvr_pkg::M_TDATA_W - $bits(kjvr_pkg::result_t))'(0), res
  };

endmodule

`default_nettype wire

@@ tb/tb_keyboard_jog_velocity_ramp_unit.sv @@
`default_nettype none

module tb_keyboard_jog_velocity_ramp_unit;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int BATCH_ITEMS   = 85;
  localparam int AGE_CEIL      = 2047;
  localparam longint LIMIT_TOP = 524287;

  // Joint position window in Q16 radians.
  localparam longint JOG_LO [kjvr_pkg::NUM_CMD] =
    '{-205888, -194452, -5719, -197309, -115527, -197309};
  localparam longint JOG_HI [kjvr_pkg::NUM_CMD] =
    '{137259, 11438, 205888, 197309, 115527, 197309};

  // Direction keys in latch bit order: even bits positive, odd bits negative.
  localparam logic [kjvr_pkg::KEY_W-1:0] DIR_KEYS [12] = '{
    kjvr_pkg::KEY_J0_POS, kjvr_pkg::KEY_J0_NEG, kjvr_pkg::KEY_J1_POS,
    kjvr_pkg::KEY_J1_NEG, kjvr_pkg::KEY_J2_POS, kjvr_pkg::KEY_J2_NEG,
    kjvr_pkg::KEY_J3_POS, kjvr_pkg::KEY_J3_NEG, kjvr_pkg::KEY_J4_POS,
    kjvr_pkg::KEY_J4_NEG, kjvr_pkg::KEY_J5_POS, kjvr_pkg::KEY_J5_NEG
  };

  typedef struct packed {
    kjvr_pkg::kind_e                                 kind;
    logic [kjvr_pkg::KEY_W-1:0]                      key;
    logic                                            pos_valid;
    logic [kjvr_pkg::NUM_CMD-1:0][kjvr_pkg::POS_W-1:0] pos;
  } jog_item_t;

  // Clock, reset and block ports.
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_axis_tready_o;
  logic [kjvr_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [kjvr_pkg::KIND_W-1:0]    s_tuser = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_tready = 1'b0;
  logic [kjvr_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic                           cfg_we_i = 1'b0;
  logic [kjvr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [kjvr_pkg::LIM_W-1:0]     cfg_wdata_i = '0;

  // Stimulus and expected results.
  jog_item_t           jog_items [$];
  jog_item_t           drv_item;
  kjvr_pkg::result_t   predicted_cmds [$];
  kjvr_pkg::result_t   mon_got;
  kjvr_pkg::result_t   mon_want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int stall_cycles  = 0;
  int n_keys        = 0;
  int n_ticks       = 0;
  int n_cmds        = 0;
  int n_other       = 0;
  int n_checked     = 0;
  int n_settings    = 0;

  // Shadow state of the jog generator.
  longint           joint_vel [kjvr_pkg::NUM_CMD] = '{default: 0};
  int               hold_age [kjvr_pkg::NUM_CMD] = '{default: 0};
  logic [11:0]      dir_latch = '0;
  longint           vel_limit = 51472;
  longint           accel_q = 412;
  longint           decel_q = 206;
  longint           hold_q = 100;
  longint           lim_step_q = 6554;
  longint           lim_reset_q = 205887;
  longint           lim_ceil_q = 411775;
  longint           lim_floor_q = 6554;

  keyboard_jog_velocity_ramp_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Key press: latch a direction or move the velocity limit.
  task automatic jog_press_key(input logic [kjvr_pkg::KEY_W-1:0] code);
    int hit;
    hit = -1;
    for (int b = 0; b < 12; b++) begin
      if (code == DIR_KEYS[b]) hit = b;
    end
    if (hit >= 0) begin
      dir_latch[hit] = 1'b1;
      hold_age[hit / 2] = 0;
    end else if (code == kjvr_pkg::KEY_LIM_DN) begin
      if (vel_limit > lim_floor_q) begin
        vel_limit = vel_limit - lim_step_q;
        if (vel_limit < 0) vel_limit = 0;
      end
    end else if (code == kjvr_pkg::KEY_LIM_RST) begin
      vel_limit = lim_reset_q;
    end else if (code == kjvr_pkg::KEY_LIM_UP) begin
      if (vel_limit < lim_ceil_q - lim_step_q) begin
        vel_limit = vel_limit + lim_step_q;
        if (vel_limit > LIMIT_TOP) vel_limit = LIMIT_TOP;
      end
    end
  endtask

  // Tick: age the latches, then ramp or decay every joint.
  task automatic jog_tick();
    longint v;
    for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
      v = joint_vel[j];
      if (hold_age[j] < AGE_CEIL) hold_age[j]++;
      if (hold_age[j] > hold_q) dir_latch[2*j +: 2] = 2'b00;
      if (dir_latch[2*j]) begin
        v = (v < vel_limit - accel_q) ? v + accel_q : vel_limit;
      end else if (dir_latch[2*j+1]) begin
        v = (v > -vel_limit + accel_q) ? v - accel_q : -vel_limit;
      end else if (v > decel_q) begin
        v = v - decel_q;
      end else if (v < -decel_q) begin
        v = v + decel_q;
      end else begin
        v = 0;
      end
      joint_vel[j] = v;
    end
  endtask

  // Command request: snapshot of the velocities (joints 3 to 5 halved), clipped at the joint window.
  function automatic kjvr_pkg::result_t jog_command(input jog_item_t it);
    kjvr_pkg::result_t                 r;
    longint                            c;
    longint                            p;
    logic signed [kjvr_pkg::POS_W-1:0] p19;
    r = '0;
    for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
      c = joint_vel[j];
      if (j >= 3) c = c >>> 1;
      if (it.pos_valid) begin
        p19 = it.pos[j];
        p = p19;
        if (p < JOG_LO[j] && c < 0) c = 0;
        if (p > JOG_HI[j] && c > 0) c = 0;
      end
      r.cmd[j] = c[kjvr_pkg::VEL_W-1:0];
    end
    r.limit = vel_limit[kjvr_pkg::LIM_W-1:0];
    return r;
  endfunction

  // Advance the shadow state by one accepted transaction.
  task automatic jog_apply(input jog_item_t it);
    case (it.kind)
      kjvr_pkg::KIND_KEY: begin
        jog_press_key(it.key);
        n_keys++;
      end
      kjvr_pkg::KIND_TICK: begin
        jog_tick();
        n_ticks++;
      end
      kjvr_pkg::KIND_CMD: begin
        predicted_cmds.insert(predicted_cmds.size(), jog_command(it));
        n_cmds++;
      end
      default: n_other++;
    endcase
  endtask

  function automatic logic [kjvr_pkg::S_TDATA_W-1:0] pack_item(input jog_item_t it);
    logic [kjvr_pkg::S_TDATA_W-1:0] d;
    d = '0;
    d[kjvr_pkg::KEY_W-1:0] = it.key;
    d[kjvr_pkg::POS_VALID_BIT] = it.pos_valid;
    for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
      d[kjvr_pkg::POS_LSB + kjvr_pkg::POS_W*j +: kjvr_pkg::POS_W] = it.pos[j];
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: presents queued items and tracks the shadow state on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_axis_tready_o) jog_apply(drv_item);
      if (!s_tvalid || s_axis_tready_o) begin
        if (jog_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = jog_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= pack_item(drv_item);
          s_tuser  <= drv_item.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid_o && m_tready) begin
        mon_got = m_axis_tdata_o[$bits(kjvr_pkg::result_t)-1:0];
        if (predicted_cmds.size() == 0) begin
          report_mismatch("result transaction with no command request pending");
        end else begin
          mon_want = predicted_cmds.pop_front();
          n_checked++;
          for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
            if (mon_got.cmd[j] !== mon_want.cmd[j]) begin
              report_mismatch($sformatf("cmd_%0d got %0d expected %0d", j,
                $signed(mon_got.cmd[j]), $signed(mon_want.cmd[j])));
            end
          end
          if (mon_got.limit !== mon_want.limit) begin
            report_mismatch($sformatf("current_limit got %0d expected %0d",
              mon_got.limit, mon_want.limit));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_keyboard_jog_velocity_ramp_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input kjvr_pkg::cfg_idx_e idx,
                           input logic [kjvr_pkg::LIM_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      kjvr_pkg::CFG_ACCEL_STEP:  accel_q     = val[kjvr_pkg::STEP_W-1:0];
      kjvr_pkg::CFG_DECEL_STEP:  decel_q     = val[kjvr_pkg::STEP_W-1:0];
      kjvr_pkg::CFG_HOLD_TICKS:  hold_q      = val[kjvr_pkg::HOLD_W-1:0];
      kjvr_pkg::CFG_LIMIT_STEP:  lim_step_q  = val[kjvr_pkg::STEP_W-1:0];
      kjvr_pkg::CFG_LIMIT_RESET: lim_reset_q = val;
      kjvr_pkg::CFG_LIMIT_CEIL:  lim_ceil_q  = val;
      kjvr_pkg::CFG_LIMIT_FLOOR: lim_floor_q = val;
      default: ;
    endcase
  endtask

  // Writes the whole register set back to back, then releases the port.
  task automatic load_settings(input logic [kjvr_pkg::LIM_W-1:0] acc, dec, hold, step,
                               input logic [kjvr_pkg::LIM_W-1:0] rst_val, ceil, flr);
    write_reg(kjvr_pkg::CFG_ACCEL_STEP, acc);
    write_reg(kjvr_pkg::CFG_DECEL_STEP, dec);
    write_reg(kjvr_pkg::CFG_HOLD_TICKS, hold);
    write_reg(kjvr_pkg::CFG_LIMIT_STEP, step);
    write_reg(kjvr_pkg::CFG_LIMIT_RESET, rst_val);
    write_reg(kjvr_pkg::CFG_LIMIT_CEIL, ceil);
    write_reg(kjvr_pkg::CFG_LIMIT_FLOOR, flr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  // Waits until every item is accepted and every command result has arrived.
  task automatic drain();
    while (jog_items.size() != 0 || s_tvalid || predicted_cmds.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_item(input kjvr_pkg::kind_e k,
                            input logic [kjvr_pkg::KEY_W-1:0] code,
                            input logic pv, input logic [kjvr_pkg::POS_W-1:0] p);
    jog_item_t it;
    it.kind = k;
    it.key = code;
    it.pos_valid = pv;
    for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) it.pos[j] = p;
    jog_items.insert(jog_items.size(), it);
  endtask

  // Mostly meaningful keys, ticks and command requests; some noise bytes.
  function automatic jog_item_t random_item();
    jog_item_t   it;
    logic [31:0] rnd;
    longint      p;
    int          sel;
    rnd = $urandom;
    it.key = rnd[kjvr_pkg::KEY_W-1:0];
    it.pos_valid = rnd[kjvr_pkg::KEY_W];
    for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
      rnd = $urandom;
      it.pos[j] = rnd[kjvr_pkg::POS_W-1:0];
    end
    sel = $urandom_range(0, 99);
    if (sel < 42) begin
      it.kind = kjvr_pkg::KIND_KEY;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        it.key = DIR_KEYS[$urandom_range(0, 11)];
      end else if (sel < 88) begin
        case ($urandom_range(0, 2))
          0: it.key = kjvr_pkg::KEY_LIM_DN;
          1: it.key = kjvr_pkg::KEY_LIM_RST;
          default: it.key = kjvr_pkg::KEY_LIM_UP;
        endcase
      end
    end else if (sel < 78) begin
      it.kind = kjvr_pkg::KIND_TICK;
    end else if (sel < 97) begin
      it.kind = kjvr_pkg::KIND_CMD;
      // Each joint, with even odds, sits within 2 of an edge of its window.
      for (int j = 0; j < kjvr_pkg::NUM_CMD; j++) begin
        if ($urandom_range(0, 1) == 1) begin
          p = ($urandom_range(0, 1) == 1) ? JOG_HI[j] : JOG_LO[j];
          p = p + int'($urandom_range(0, 4)) - 2;
          it.pos[j] = p[kjvr_pkg::POS_W-1:0];
        end
      end
    end else begin
      it.kind = kjvr_pkg::KIND_RSVD;
    end
    return it;
  endfunction

  task automatic random_batch(input int count);
    for (int i = 0; i < count; i++) jog_items.insert(jog_items.size(), random_item());
  endtask

  // Sequence of phases.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Receiver-heavy stalls first.
    send_idle_pct = 19;
    recv_idle_pct = 53;

    // Directed: latches with both directions pressed, limit keys, window clipping.
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J0_POS, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J0_NEG, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J1_NEG, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J2_POS, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J3_NEG, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J4_POS, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J4_NEG, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_J5_NEG, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_TICK, '0, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_TICK, '0, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_CMD, '0, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_LIM_UP, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_LIM_RST, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, kjvr_pkg::KEY_LIM_DN, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_KEY, 8'hFF, 1'b1, '1);
    queue_item(kjvr_pkg::KIND_RSVD, 8'hFF, 1'b1, '1);
    queue_item(kjvr_pkg::KIND_TICK, '0, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_CMD, '0, 1'b1, 19'h40000);
    queue_item(kjvr_pkg::KIND_CMD, '0, 1'b1, 19'h3FFFF);
    queue_item(kjvr_pkg::KIND_KEY, 8'h00, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_TICK, '0, 1'b0, '0);
    queue_item(kjvr_pkg::KIND_CMD, '0, 1'b1, '0);
    queue_item(kjvr_pkg::KIND_CMD, '0, 1'b0, 19'h3FFFF);
    drain();

    random_batch(BATCH_ITEMS);
    drain();

    // Sender-heavy gaps; every register at its top value.
    send_idle_pct = 53;
    recv_idle_pct = 19;
    write_reg(kjvr_pkg::CFG_UNUSED, '1);
    load_settings('1, '1, '1, '1, '1, '1, '1);
    random_batch(BATCH_ITEMS);
    drain();

    // Every register at zero: latches drop on the first tick.
    load_settings('0, '0, '0, '0, '0, '0, '0);
    random_batch(BATCH_ITEMS);
    drain();

    // Full rate on both sides with random settings.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(19'($urandom_range(50, 4000)), 19'($urandom_range(20, 3000)),
                  19'($urandom_range(1, 40)), 19'($urandom_range(0, 65535)),
                  19'($urandom_range(0, 524287)), 19'($urandom_range(0, 524287)),
                  19'($urandom_range(0, 200000)));
    random_batch(BATCH_ITEMS);
    drain();

    load_settings(19'($urandom_range(100, 20000)), 19'($urandom_range(100, 20000)),
                  19'($urandom_range(2, 200)), 19'($urandom_range(1000, 40000)),
                  19'($urandom_range(20000, 300000)), 19'($urandom_range(50000, 524287)),
                  19'($urandom_range(0, 50000)));
    random_batch(BATCH_ITEMS);
    drain();

    $display("run: %0d key, %0d tick, %0d command and %0d reserved transactions",
             n_keys, n_ticks, n_cmds, n_other);
    $display("run: %0d results compared across %0d register settings, %0d mismatches",
             n_checked, n_settings + 1, error_count);
    if (error_count == 0) begin
      $display("tb_keyboard_jog_velocity_ramp_unit: clean");
    end else begin
      $display("tb_keyboard_jog_velocity_ramp_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
